[rtl/core/heading_angle_arctangent_macros.svh]
// ----------------------------------------------------------------------------
// heading angle arctangent assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HEADING_ANGLE_ARCTANGENT_MACROS_SVH
`define HEADING_ANGLE_ARCTANGENT_MACROS_SVH

// same-cycle implication
`define HDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hda_pkg.sv]
// ----------------------------------------------------------------------------
// hda_pkg
// types, constants and the arctangent table of the heading angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package hda_pkg;

  localparam int GUARD_BITS  = 14;
  localparam int TABLE_LEN   = 24;
  localparam int TABLE_IDX_W = 5;
  localparam int ZW          = 32;
  localparam int HEADING_W   = 16;
  localparam int ROUND_SHIFT = 16;

  localparam logic signed [ZW-1:0]        ROUND_HALF  = 32'sd32768;
  localparam logic signed [HEADING_W-1:0] PI_Q12      = 16'sd12868;
  localparam logic signed [HEADING_W-1:0] HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [HEADING_W-1:0] HEADING_MIN = -16'sd19302;

  typedef struct packed {
    logic dx_zero;
    logic dy_pos;
    logic dx_pos;
  } hda_flags_t;

  // atan(2^-i) scaled by 2^28
  function automatic logic signed [ZW-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hda_prep.sv]
// ----------------------------------------------------------------------------
// hda_prep
// forms dx and dy, folds the vector into the right half plane and scales it
// ----------------------------------------------------------------------------
`default_nettype none

module hda_prep
  import hda_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int XW         = 35
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] source_x,
  input  logic signed [COORD_BITS-1:0] source_y,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [XW-1:0]         x_out,
  output logic signed [XW-1:0]         y_out,
  output hda_flags_t                   flags_out
);

  localparam int EXT = XW - COORD_BITS - 2 - GUARD_BITS;

  logic signed [COORD_BITS:0]   dx, dy;
  logic signed [COORD_BITS+1:0] dxw, dyw, xa, ya;
  logic signed [XW-1:0]         x_nxt, y_nxt, x_r, y_r;
  hda_flags_t                   flags_nxt, flags_r;
  logic                         valid_r, load;

  always_comb begin
    dx  = {target_x[COORD_BITS-1], target_x} - {source_x[COORD_BITS-1], source_x};
    dy  = {target_y[COORD_BITS-1], target_y} - {source_y[COORD_BITS-1], source_y};
    dxw = {dx[COORD_BITS], dx};
    dyw = {dy[COORD_BITS], dy};
    xa  = dx[COORD_BITS] ? -dxw : dxw;
    ya  = dx[COORD_BITS] ? -dyw : dyw;
    x_nxt = {{EXT{xa[COORD_BITS+1]}}, xa, {GUARD_BITS{1'b0}}};
    y_nxt = {{EXT{ya[COORD_BITS+1]}}, ya, {GUARD_BITS{1'b0}}};
    flags_nxt.dx_zero = (dx == '0);
    flags_nxt.dy_pos  = !dy[COORD_BITS] && (dy != '0);
    flags_nxt.dx_pos  = !dx[COORD_BITS] && (dx != '0);
  end

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign flags_out = flags_r;

endmodule

`default_nettype wire

[rtl/core/hda_cordic_stage.sv]
// ----------------------------------------------------------------------------
// hda_cordic_stage
// one registered vectoring iteration with a fixed shift and table entry
// ----------------------------------------------------------------------------
`default_nettype none

module hda_cordic_stage
  import hda_pkg::*;
#(
  parameter int XW   = 35,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  hda_flags_t           flags_in,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output hda_flags_t           flags_out
);

  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic signed [ZW-1:0] angle, z_nxt, z_r;
  hda_flags_t           flags_r;
  logic                 valid_r, load;

  always_comb begin
    xs    = x_in >>> STEP;
    ys    = y_in >>> STEP;
    angle = atan_entry(TABLE_IDX_W'(STEP));
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + angle;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - angle;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      flags_r <= flags_in;
    end
  end

  assign dn_valid  = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign flags_out = flags_r;

endmodule

`default_nettype wire

[rtl/core/hda_post.sv]
// ----------------------------------------------------------------------------
// hda_post
// rounds the angle to q4.12, saturates it, applies special cases and pi offset
// ----------------------------------------------------------------------------
`default_nettype none

`include "heading_angle_arctangent_macros.svh"

module hda_post
  import hda_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [ZW-1:0]        z_in,
  input  hda_flags_t                  flags_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [HEADING_W-1:0] out_heading
);

  logic signed [ZW-1:0]        sum;
  logic signed [HEADING_W-1:0] rounded, sat, heading_nxt, heading_r;
  logic                        valid_r, load;

  always_comb begin
    sum     = z_in + ROUND_HALF;
    rounded = sum[ROUND_SHIFT +: HEADING_W];
    if (rounded > HALF_PI_Q12) begin
      sat = HALF_PI_Q12;
    end else if (rounded < -HALF_PI_Q12) begin
      sat = -HALF_PI_Q12;
    end else begin
      sat = rounded;
    end
    if (flags_in.dx_zero) begin
      heading_nxt = flags_in.dy_pos ? HALF_PI_Q12 : '0;
    end else if (flags_in.dx_pos) begin
      heading_nxt = sat - PI_Q12;
    end else begin
      heading_nxt = sat;
    end
  end

  assign up_ready = !valid_r || !out_stall;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_heading = heading_r;

  `HDA_ASSERT_IMPL(a_flags_exclusive, up_valid, !(flags_in.dx_zero && flags_in.dx_pos), "dx zero and positive together")
  `HDA_ASSERT_IMPL(a_heading_range, valid_r, (heading_r <= HALF_PI_Q12) && (heading_r >= HEADING_MIN), "heading out of range")
  `HDA_ASSERT_NEXT(a_load_shows, load, valid_r, "loaded result not presented")

endmodule

`default_nettype wire

[rtl/core/heading_angle_arctangent.sv]
// ----------------------------------------------------------------------------
// heading_angle_arctangent
// heading from a source point to a target point by pipelined cordic vectoring
// ----------------------------------------------------------------------------
// Takes one coordinate pair per cycle while in_stall is low and returns the
// heading atan(dy/dx) in signed Q4.12 radians, with pi subtracted when the
// target lies to the right of the source, and pi/2 or 0 when dx is zero. Each
// transfer passes one difference stage, one register stage per CORDIC
// iteration (CORDIC_STEPS, capped at 24) and one rounding stage, in that order,
// and the result is presented at the output from the rounding register.
// Stages advance independently, so bubbles close up and input keeps being
// taken while a result waits at the output as long as any stage is empty.
`default_nettype none

module heading_angle_arctangent
  import hda_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_source_x,
  input  logic signed [COORD_BITS-1:0] in_source_y,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [HEADING_W-1:0]  out_heading
);

  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int XW    = COORD_BITS + GUARD_BITS + 5;

  logic                 v_s   [0:STEPS];
  logic                 rdy_s [0:STEPS];
  logic signed [XW-1:0] x_s   [0:STEPS];
  logic signed [XW-1:0] y_s   [0:STEPS];
  logic signed [ZW-1:0] z_s   [0:STEPS];
  hda_flags_t           f_s   [0:STEPS];
  logic                 in_ready;

  assign in_stall = !in_ready;
  assign z_s[0]   = '0;

  hda_prep #(
    .COORD_BITS (COORD_BITS),
    .XW         (XW)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .source_x  (in_source_x),
    .source_y  (in_source_y),
    .target_x  (in_target_x),
    .target_y  (in_target_y),
    .dn_valid  (v_s[0]),
    .dn_ready  (rdy_s[0]),
    .x_out     (x_s[0]),
    .y_out     (y_s[0]),
    .flags_out (f_s[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    hda_cordic_stage #(
      .XW   (XW),
      .STEP (g)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (v_s[g]),
      .up_ready  (rdy_s[g]),
      .x_in      (x_s[g]),
      .y_in      (y_s[g]),
      .z_in      (z_s[g]),
      .flags_in  (f_s[g]),
      .dn_valid  (v_s[g+1]),
      .dn_ready  (rdy_s[g+1]),
      .x_out     (x_s[g+1]),
      .y_out     (y_s[g+1]),
      .z_out     (z_s[g+1]),
      .flags_out (f_s[g+1])
    );
  end

  hda_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (v_s[STEPS]),
    .up_ready    (rdy_s[STEPS]),
    .z_in        (z_s[STEPS]),
    .flags_in    (f_s[STEPS]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_heading (out_heading)
  );

endmodule

`default_nettype wire

[bench/heading_checker.sv]
// ----------------------------------------------------------------------------
// heading_checker
// predicts and checks every heading that the arctangent pipeline returns
// ----------------------------------------------------------------------------
// Watches both channels of the block. Each input transfer yields one expected
// heading, computed here by its own CORDIC vectoring predictor. Expected
// headings wait in order, and each output transfer is compared with the
// oldest of them. The failure count and the number of headings still due are
// handed back to the top.
`default_nettype none

module heading_checker
  import hda_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic signed [15:0]          in_source_x,
  input  wire logic signed [15:0]          in_source_y,
  input  wire logic signed [15:0]          in_target_x,
  input  wire logic signed [15:0]          in_target_y,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic signed [HEADING_W-1:0] out_heading,
  output int                               fail_count,
  output int                               headings_due
);

  // atan(2^-i) in radians scaled by 2^28
  localparam longint ATAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  logic signed [HEADING_W-1:0] expected_headings [$];

  initial begin
    fail_count   = 0;
    headings_due = 0;
  end

  function automatic logic signed [HEADING_W-1:0] predict_heading(
    input logic signed [15:0] sx,
    input logic signed [15:0] sy,
    input logic signed [15:0] tx,
    input logic signed [15:0] ty
  );
    longint dx, dy, x, y, z, xs, ys, ang;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    if (dx == 0) begin
      ang = (dy > 0) ? longint'(HALF_PI_Q12) : 0;
    end else begin
      x = dx;
      y = dy;
      z = 0;
      // fold into the right half plane, the ratio is unchanged
      if (x < 0) begin
        x = -x;
        y = -y;
      end
      x = x * (longint'(1) << GUARD_BITS);
      y = y * (longint'(1) << GUARD_BITS);
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q28[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q28[i];
        end
      end
      ang = (z + 32768) >>> 16;
      if (ang > longint'(HALF_PI_Q12)) ang = longint'(HALF_PI_Q12);
      if (ang < -longint'(HALF_PI_Q12)) ang = -longint'(HALF_PI_Q12);
    end
    if (dx > 0) ang = ang - longint'(PI_Q12);
    return ang[HEADING_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [HEADING_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_headings.size() == 0) begin
          report_mismatch($sformatf("heading %0d with none due", out_heading));
        end else begin
          want = expected_headings.pop_front();
          if (out_heading !== want)
            report_mismatch($sformatf("heading got %0d want %0d", out_heading, want));
        end
      end
      if (in_valid && !in_stall)
        expected_headings.push_back(
          predict_heading(in_source_x, in_source_y, in_target_x, in_target_y));
      headings_due = expected_headings.size();
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the heading angle arctangent pipeline
// ----------------------------------------------------------------------------
// Drives directed coordinate pairs at the edges of the range and around
// dx = 0, then random pairs biased towards vertical, horizontal, diagonal and
// short vectors. Both channels idle in random bursts, and the final stretch
// runs at full rate. A checker beside the block predicts every heading.
`default_nettype none

module testbench;
  import hda_pkg::*;

  localparam int STEPS       = 16;
  localparam int RANDOM_PAIRS = 1750;
  localparam int CALM_FROM   = 1500;
  localparam int CYCLE_LIMIT = 400000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [15:0]          in_source_x = '0;
  logic signed [15:0]          in_source_y = '0;
  logic signed [15:0]          in_target_x = '0;
  logic signed [15:0]          in_target_y = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [HEADING_W-1:0] out_heading;

  int fail_count;
  int headings_due;
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heading_angle_arctangent #(
    .CORDIC_STEPS(STEPS),
    .COORD_BITS  (16)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_source_x(in_source_x),
    .in_source_y(in_source_y),
    .in_target_x(in_target_x),
    .in_target_y(in_target_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_heading(out_heading)
  );

  heading_checker #(
    .CORDIC_STEPS(STEPS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_source_x (in_source_x),
    .in_source_y (in_source_y),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_heading (out_heading),
    .fail_count  (fail_count),
    .headings_due(headings_due)
  );

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall <= (stall_left > 0);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pair(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] tx, input logic [15:0] ty);
    in_valid    <= 1'b1;
    in_source_x <= sx;
    in_source_y <= sy;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (headings_due != 0) @(posedge clk);
  endtask

  task automatic send_random_pair();
    logic [15:0] sx, sy, tx, ty, step;
    sx   = 16'($urandom);
    sy   = 16'($urandom);
    tx   = 16'($urandom);
    ty   = 16'($urandom);
    step = 16'($urandom_range(0, 40)) - 16'd20;
    case ($urandom_range(0, 9))
      0: tx = sx;
      1: ty = sy;
      2: begin
        tx = sx + step;
        ty = sy + 16'($urandom_range(0, 40)) - 16'd20;
      end
      3: ty = ($urandom_range(0, 1) != 0) ? sy + (tx - sx) : sy - (tx - sx);
      default: ;
    endcase
    send_pair(sx, sy, tx, ty);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_odds   = 4;
    stall_odds = 4;

    // vertical and degenerate vectors
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd5);
    send_pair(16'sd0, 16'sd0, 16'sd0, -16'sd5);
    send_pair(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    send_pair(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    // widest and shortest horizontal spans
    send_pair(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
    send_pair(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd0, -16'sd1, 16'sd0);
    // near vertical, close to saturation
    send_pair(16'sd0, -16'sd32768, 16'sd1, 16'sd32767);
    send_pair(16'sd0, -16'sd32768, -16'sd1, 16'sd32767);
    send_pair(16'sd0, 16'sd32767, 16'sd1, -16'sd32768);
    send_pair(16'sd0, 16'sd32767, -16'sd1, -16'sd32768);
    // corners of the difference range
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    // diagonals
    send_pair(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    send_pair(16'sd0, 16'sd0, -16'sd100, 16'sd100);
    send_pair(16'sd0, 16'sd0, 16'sd100, -16'sd100);
    send_pair(16'sd0, 16'sd0, -16'sd100, -16'sd100);
    wait_drained();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n >= CALM_FROM) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 10;
        endcase
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 3;
          default: stall_odds = 10;
        endcase
      end
      if (n == RANDOM_PAIRS / 2) wait_drained();
      send_random_pair();
    end

    wait_drained();
    repeat (STEPS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
